>>> src/port_latch_sram_keyscan_glue_assert.svh
// ---------------------------------------------------------------------------
// port_latch_sram_keyscan_glue_assert
// Assertion macros for the port glue block; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef PORT_LATCH_SRAM_KEYSCAN_GLUE_ASSERT_SVH
`define PORT_LATCH_SRAM_KEYSCAN_GLUE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PLSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plsk: same-cycle check failed");

// next-cycle implication
`define PLSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plsk: next-cycle check failed");

`else

`define PLSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PLSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/plsk_pkg.sv
// ---------------------------------------------------------------------------
// plsk_pkg
// Types, codes and constants of the port latch / nibble RAM / key scan glue.
// ---------------------------------------------------------------------------
`default_nettype none

package plsk_pkg;

  // field widths
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned KEYS_W = 36;

  // nibble ram geometry
  localparam int unsigned RAM_DEPTH = 2048;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  // access modes
  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_READ_A = 3'd1;
  localparam logic [2:0] MODE_READ_B = 3'd2;
  localparam logic [2:0] MODE_READ_C = 3'd3;
  localparam logic [2:0] MODE_READ_D = 3'd4;

  // port codes that hold a latch
  localparam logic [3:0] PORT_C = 4'd2;
  localparam logic [3:0] PORT_D = 4'd3;
  localparam logic [3:0] PORT_E = 4'd4;
  localparam logic [3:0] PORT_F = 4'd5;
  localparam logic [3:0] PORT_G = 4'd6;
  localparam logic [3:0] PORT_H = 4'd7;
  localparam logic [3:0] PORT_I = 4'd8;

  // configuration register indexes
  localparam logic CFG_CE_LEVEL = 1'b0;
  localparam logic CFG_WE_LEVEL = 1'b1;

  // scan row code that selects the status group
  localparam logic [2:0] ROW_STATUS = 3'd4;

  // mask of the status group bits kept below the live clock
  localparam logic [NIB_W-2:0] STATUS_LOW_MASK = 3'h7;

  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        port;
    logic [NIB_W-1:0]  data;
    logic [KEYS_W-1:0] keys;
    logic              clock_present;
    logic              live_clock;
  } in_item_t;

  typedef struct packed {
    logic [NIB_W-1:0] read_data;
    logic             write_forward;
    logic [3:0]       forward_port;
    logic [NIB_W-1:0] forward_data;
    logic             ram_dirty;
  } out_item_t;

  // item state between the accept stage and the result stage
  typedef struct packed {
    logic [NIB_W-1:0]  read_data;
    logic              write_forward;
    logic [3:0]        forward_port;
    logic [NIB_W-1:0]  forward_data;
    logic              commit;
    logic              cread;
    logic [RAM_AW-1:0] addr;
    logic [NIB_W-1:0]  wdata;
    logic              bypass;
    logic [NIB_W-1:0]  byp_data;
  } mid_t;

  // row of the lowest clear scan bit, status group when none is clear
  function automatic logic [2:0] lowest_clear_row(input logic [3:0] scan);
    logic [2:0] row;
    unique case (scan)
      4'h0, 4'h2, 4'h4, 4'h6, 4'h8, 4'hA, 4'hC, 4'hE: row = 3'd0;
      4'h1, 4'h5, 4'h9, 4'hD:                         row = 3'd1;
      4'h3, 4'hB:                                     row = 3'd2;
      4'h7:                                           row = 3'd3;
      default:                                        row = ROW_STATUS;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

>>> src/plsk_ram.sv
// ---------------------------------------------------------------------------
// plsk_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module plsk_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/port_latch_sram_keyscan_glue.sv
// ---------------------------------------------------------------------------
// port_latch_sram_keyscan_glue
// Output port latches, 2048 x 4 nibble RAM with dirty tracking, key scanner.
// ---------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   -------------------------------------
//  in        in_valid / in_stall       in_item  (mode, port, data, keys, ...)
//  out       out_valid / out_stall     out_item (read_data, forward, dirty)
//  cfg       cfg_we                    cfg_index, cfg_data (active levels)
//
//  One item per cycle sustained while neither out_stall nor the clearing pass
//  holds the flow; an accepted item goes through the middle register and then
//  the output register. Latches update at accept; the RAM is read at accept
//  and the old nibble is compared and written back as the item leaves the
//  middle stage, with a bypass for back to back hits on the same address.
//  After reset a clearing pass zeroes every RAM address with in_stall high.
//  A stalled result is held in the output register; one more item waits in the
//  middle stage before in_stall rises.
//
`default_nettype none

`include "port_latch_sram_keyscan_glue_assert.svh"

module port_latch_sram_keyscan_glue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire plsk_pkg::in_item_t in_item,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      plsk_pkg::out_item_t out_item,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic               cfg_data
);

  localparam int unsigned AW = plsk_pkg::RAM_AW;
  localparam int unsigned NW = plsk_pkg::NIB_W;

  // configuration
  logic ce_level_r, we_level_r;

  // latches
  logic [NW-1:0] data_latch_r, rhythm_latch_r, bank_latch_r, step_latch_r;
  logic [NW-1:0] led_latch_r, scan_latch_r, strobe_latch_r;
  logic [NW-1:0] data_latch_nxt, rhythm_latch_nxt, bank_latch_nxt, step_latch_nxt;
  logic [NW-1:0] led_latch_nxt, scan_latch_nxt, strobe_latch_nxt;
  logic          dirty_r, dirty_nxt;

  // clearing pass
  logic [AW:0] clr_cnt_r;
  logic        clearing;

  // pipeline control
  logic                 mid_valid_r, out_valid_r;
  plsk_pkg::mid_t       mid_r, mid_nxt;
  plsk_pkg::out_item_t  out_r;
  logic                 accept, mid_advance;

  // accept-stage signals
  logic          commit_port, ce_on, we_on;
  logic [AW-1:0] addr_nxt;
  logic [2:0]    row;
  logic [NW-1:0] key_a, key_b, rd_nxt;

  // result-stage signals
  logic [NW-1:0] ram_rdata, mem_val;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [NW-1:0] ram_wdata;

  assign clearing    = !clr_cnt_r[AW];
  assign mid_advance = mid_valid_r && (!out_valid_r || !out_stall);
  assign in_stall    = clearing || (mid_valid_r && !mid_advance);
  assign accept      = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ce_level_r <= 1'b1;
      we_level_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plsk_pkg::CFG_CE_LEVEL: ce_level_r <= cfg_data;
        plsk_pkg::CFG_WE_LEVEL: we_level_r <= cfg_data;
        default:                ;
      endcase
    end
  end

  // latch updates for a port write and the middle-stage item state
  always_comb begin
    data_latch_nxt   = data_latch_r;
    rhythm_latch_nxt = rhythm_latch_r;
    bank_latch_nxt   = bank_latch_r;
    step_latch_nxt   = step_latch_r;
    led_latch_nxt    = led_latch_r;
    scan_latch_nxt   = scan_latch_r;
    strobe_latch_nxt = strobe_latch_r;
    commit_port      = 1'b0;
    mid_nxt          = '0;
    if (accept && in_item.mode == plsk_pkg::MODE_WRITE) begin
      mid_nxt.write_forward = 1'b1;
      unique case (in_item.port)
        plsk_pkg::PORT_C: begin
          data_latch_nxt = in_item.data;
          commit_port    = 1'b1;
        end
        plsk_pkg::PORT_D: begin
          rhythm_latch_nxt = in_item.data;
          commit_port      = 1'b1;
        end
        plsk_pkg::PORT_E: begin
          bank_latch_nxt = in_item.data;
          commit_port    = 1'b1;
        end
        plsk_pkg::PORT_F: begin
          step_latch_nxt = in_item.data;
          commit_port    = 1'b1;
        end
        plsk_pkg::PORT_G: led_latch_nxt  = in_item.data;
        plsk_pkg::PORT_H: scan_latch_nxt = in_item.data;
        plsk_pkg::PORT_I: begin
          strobe_latch_nxt = in_item.data;
          commit_port      = 1'b1;
        end
        default: mid_nxt.write_forward = 1'b0;
      endcase
    end
    if (mid_nxt.write_forward) begin
      mid_nxt.forward_port = in_item.port;
      mid_nxt.forward_data = in_item.data;
    end

    // enables and address after this item's latch update
    ce_on    = strobe_latch_nxt[1] == ce_level_r;
    we_on    = strobe_latch_nxt[0] == we_level_r;
    addr_nxt = {bank_latch_nxt[2], bank_latch_nxt[3], bank_latch_nxt[0],
                step_latch_nxt, rhythm_latch_nxt};

    mid_nxt.commit   = commit_port && ce_on && we_on;
    mid_nxt.cread    = in_item.mode == plsk_pkg::MODE_READ_C && ce_on && !we_on;
    mid_nxt.addr     = addr_nxt;
    mid_nxt.wdata    = data_latch_nxt;
    // the item ahead writes this address at the same edge
    mid_nxt.bypass   = mid_advance && mid_r.commit && (mid_r.addr == addr_nxt);
    mid_nxt.byp_data = mid_r.wdata;
    mid_nxt.read_data = rd_nxt;
  end

  // key scan groups of the selected row
  always_comb begin
    row   = plsk_pkg::lowest_clear_row(scan_latch_r);
    key_a = '0;
    key_b = '0;
    unique case (row)
      3'd0: begin
        key_a = in_item.keys[19:16];
        key_b = in_item.keys[3:0];
      end
      3'd1: begin
        key_a = in_item.keys[23:20];
        key_b = in_item.keys[7:4];
      end
      3'd2: begin
        key_a = in_item.keys[27:24];
        key_b = in_item.keys[11:8];
      end
      3'd3: begin
        key_a = in_item.keys[31:28];
        key_b = in_item.keys[15:12];
      end
      default: begin
        key_a = in_item.keys[35:32];
        if (in_item.clock_present) begin
          key_a = {in_item.live_clock, key_a[NW-2:0] & plsk_pkg::STATUS_LOW_MASK};
        end
      end
    endcase
  end

  // read value of ports A and B, others resolved later or zero
  always_comb begin
    unique case (in_item.mode)
      plsk_pkg::MODE_READ_A: rd_nxt = key_a;
      plsk_pkg::MODE_READ_B: rd_nxt = key_b;
      plsk_pkg::MODE_READ_D: rd_nxt = '0;
      default:               rd_nxt = '0;
    endcase
  end

  // latch and pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_latch_r   <= '0;
      rhythm_latch_r <= '0;
      bank_latch_r   <= '0;
      step_latch_r   <= '0;
      led_latch_r    <= '0;
      scan_latch_r   <= '0;
      strobe_latch_r <= '0;
      dirty_r        <= 1'b0;
      mid_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      clr_cnt_r      <= '0;
    end else begin
      data_latch_r   <= data_latch_nxt;
      rhythm_latch_r <= rhythm_latch_nxt;
      bank_latch_r   <= bank_latch_nxt;
      step_latch_r   <= step_latch_nxt;
      led_latch_r    <= led_latch_nxt;
      scan_latch_r   <= scan_latch_nxt;
      strobe_latch_r <= strobe_latch_nxt;
      if (mid_advance) begin
        dirty_r <= dirty_nxt;
      end
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (accept) begin
        mid_valid_r <= 1'b1;
      end else if (mid_advance) begin
        mid_valid_r <= 1'b0;
      end
      if (mid_advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_r <= mid_nxt;
    end
    if (mid_advance) begin
      out_r.read_data     <= mid_r.cread ? mem_val : mid_r.read_data;
      out_r.write_forward <= mid_r.write_forward;
      out_r.forward_port  <= mid_r.forward_port;
      out_r.forward_data  <= mid_r.forward_data;
      out_r.ram_dirty     <= dirty_nxt;
    end
  end

  // old nibble, compare and write back
  assign mem_val   = mid_r.bypass ? mid_r.byp_data : ram_rdata;
  assign dirty_nxt = dirty_r || (mid_r.commit && (mem_val != mid_r.wdata));
  assign ram_we    = clearing || (mid_advance && mid_r.commit);
  assign ram_waddr = clearing ? clr_cnt_r[AW-1:0] : mid_r.addr;
  assign ram_wdata = clearing ? '0 : mid_r.wdata;

  plsk_ram #(
    .WIDTH (NW),
    .DEPTH (plsk_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  `PLSK_ASSERT_IMP(a_clear_quiet, clk, rst_n, clearing, !mid_valid_r && !out_valid_r)
  `PLSK_ASSERT_NXT(a_mid_hold, clk, rst_n, mid_valid_r && !mid_advance, mid_valid_r)
  `PLSK_ASSERT_NXT(a_dirty_sticky, clk, rst_n, dirty_r, dirty_r)
  `PLSK_ASSERT_IMP(a_full_stalls, clk, rst_n, mid_valid_r && out_valid_r && out_stall, in_stall)

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Sends port writes, key scans and nibble RAM accesses into the port glue
// block. The sender works in bursts with random gaps and the receiver stalls
// on its own pattern. A local model of the latches, RAM and dirty mark
// predicts every result, and results are checked in order, field by field.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 6000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 230;
  localparam int RANDOM_PHASES   = 8;
  localparam int GROUP_A_BASE    = 16;
  localparam int STATUS_BASE     = 32;

  // codes the package does not name
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [3:0] PORT_A        = 4'd0;
  localparam logic [3:0] PORT_TOP      = 4'd15;

  // receiver stall styles
  localparam logic [1:0] STALL_NONE  = 2'd0;
  localparam logic [1:0] STALL_LIGHT = 2'd1;
  localparam logic [1:0] STALL_HEAVY = 2'd2;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  plsk_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  plsk_pkg::out_item_t out_item;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = plsk_pkg::CFG_CE_LEVEL;
  logic                cfg_data  = 1'b0;

  // local copy of the block state
  logic [3:0] data_nib, rhythm_nib, bank_nib, step_nib, scan_nib, strobe_nib;
  logic [3:0] ram_image [plsk_pkg::RAM_DEPTH];
  logic       dirty_seen;
  logic       ce_level, we_level;

  plsk_pkg::out_item_t expected_results[$];
  plsk_pkg::out_item_t oldest_result;
  int        mismatch_count = 0;
  int        accepted_items = 0;
  int        burst_left     = 1;
  int        idle_cycles    = 0;
  int        stall_span     = 0;
  logic [1:0] stall_style   = STALL_NONE;

  port_latch_sram_keyscan_glue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [3:0] rand_nib();
    return 4'($urandom_range(15, 0));
  endfunction

  // row of the lowest clear scan bit, status group when none is clear
  function automatic logic [2:0] scan_row(input logic [3:0] scan);
    logic [2:0] row;
    row = plsk_pkg::ROW_STATUS;
    for (int b = 3; b >= 0; b--)
      if (!scan[b]) row = b[2:0];
    return row;
  endfunction

  function automatic logic [plsk_pkg::RAM_AW-1:0] ram_addr();
    return {bank_nib[2], bank_nib[3], bank_nib[0], step_nib, rhythm_nib};
  endfunction

  // updates the local state and returns the result of one item
  function automatic plsk_pkg::out_item_t predict_access(input plsk_pkg::in_item_t item);
    plsk_pkg::out_item_t res;
    logic [2:0] row;
    logic       stores;
    logic       ce_on, we_on;
    res    = '0;
    stores = 1'b0;
    row    = scan_row(scan_nib);
    case (item.mode)
      plsk_pkg::MODE_WRITE: begin
        res.write_forward = 1'b1;
        res.forward_port  = item.port;
        res.forward_data  = item.data;
        case (item.port)
          plsk_pkg::PORT_C: begin
            data_nib = item.data;
            stores   = 1'b1;
          end
          plsk_pkg::PORT_D: begin
            rhythm_nib = item.data;
            stores     = 1'b1;
          end
          plsk_pkg::PORT_E: begin
            bank_nib = item.data;
            stores   = 1'b1;
          end
          plsk_pkg::PORT_F: begin
            step_nib = item.data;
            stores   = 1'b1;
          end
          plsk_pkg::PORT_G: ;
          plsk_pkg::PORT_H: scan_nib = item.data;
          plsk_pkg::PORT_I: begin
            strobe_nib = item.data;
            stores     = 1'b1;
          end
          default: res = '0;
        endcase
      end
      plsk_pkg::MODE_READ_A: begin
        if (row < plsk_pkg::ROW_STATUS) begin
          res.read_data = item.keys[GROUP_A_BASE + 4 * row +: 4];
        end else begin
          res.read_data = item.keys[STATUS_BASE +: 4];
          if (item.clock_present) res.read_data[3] = item.live_clock;
        end
      end
      plsk_pkg::MODE_READ_B: begin
        if (row < plsk_pkg::ROW_STATUS) res.read_data = item.keys[4 * row +: 4];
      end
      default: ;
    endcase
    ce_on = (strobe_nib[1] == ce_level);
    we_on = (strobe_nib[0] == we_level);
    // ram read only when enabled and not writing
    if (item.mode == plsk_pkg::MODE_READ_C && ce_on && !we_on)
      res.read_data = ram_image[ram_addr()];
    // store the data latch, dirty only on a real change
    if (stores && ce_on && we_on && ram_image[ram_addr()] != data_nib) begin
      ram_image[ram_addr()] = data_nib;
      dirty_seen            = 1'b1;
    end
    res.ram_dirty = dirty_seen;
    return res;
  endfunction

  function automatic plsk_pkg::in_item_t make_item(input logic [2:0] mode,
                                                   input logic [3:0] port,
                                                   input logic [3:0] data);
    plsk_pkg::in_item_t item;
    item.mode          = mode;
    item.port          = port;
    item.data          = data;
    item.keys[31:0]    = $urandom();
    item.keys[35:32]   = rand_nib();
    item.clock_present = 1'($urandom_range(1, 0));
    item.live_clock    = 1'($urandom_range(1, 0));
    return item;
  endfunction

  function automatic logic [3:0] addr_port();
    case ($urandom_range(2, 0))
      0:       return plsk_pkg::PORT_D;
      1:       return plsk_pkg::PORT_E;
      default: return plsk_pkg::PORT_F;
    endcase
  endfunction

  // mostly a small address pool so reads hit earlier stores
  function automatic logic [3:0] pool_nib();
    return ($urandom_range(3, 0) == 0) ? rand_nib() : 4'($urandom_range(3, 0));
  endfunction

  // send one item, record its prediction at accept, idle between bursts
  task automatic send_item(input plsk_pkg::in_item_t item);
    in_item  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_access(item));
    accepted_items++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 30)
                                               : $urandom_range(12, 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_levels(input logic ce, input logic we);
    cfg_we    <= 1'b1;
    cfg_index <= plsk_pkg::CFG_CE_LEVEL;
    cfg_data  <= ce;
    @(posedge clk);
    ce_level = ce;
    cfg_index <= plsk_pkg::CFG_WE_LEVEL;
    cfg_data  <= we;
    @(posedge clk);
    we_level = we;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ignored ports and unused modes
  task automatic test_spare_codes();
    send_item(make_item(plsk_pkg::MODE_WRITE, PORT_A, 4'hF));
    send_item(make_item(plsk_pkg::MODE_WRITE, PORT_TOP, 4'hF));
    send_item(make_item(MODE_SPARE_LO, PORT_TOP, 4'hF));
    send_item(make_item(MODE_SPARE_HI, PORT_A, 4'h0));
  endtask

  // key rows, status group and live clock override
  task automatic test_key_scan();
    plsk_pkg::in_item_t item;
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_H, 4'hE));
    item      = make_item(plsk_pkg::MODE_READ_A, PORT_A, 4'h0);
    item.keys = '1;
    send_item(item);
    item      = make_item(plsk_pkg::MODE_READ_B, PORT_A, 4'h0);
    item.keys = 36'h0_0000_000F;
    send_item(item);
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_H, 4'h7));
    item      = make_item(plsk_pkg::MODE_READ_A, PORT_A, 4'h0);
    item.keys = 36'h0_F000_0000;
    send_item(item);
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_H, 4'hF));
    item               = make_item(plsk_pkg::MODE_READ_A, PORT_A, 4'h0);
    item.keys          = 36'hF_0000_0000;
    item.clock_present = 1'b1;
    item.live_clock    = 1'b0;
    send_item(item);
    item.keys       = '0;
    item.live_clock = 1'b1;
    send_item(item);
    item      = make_item(plsk_pkg::MODE_READ_B, PORT_A, 4'h0);
    item.keys = '1;
    send_item(item);
    item      = make_item(plsk_pkg::MODE_READ_D, PORT_A, 4'h0);
    item.keys = '1;
    send_item(item);
  endtask

  // stores at the top address, unchanged stores, gated reads of port c
  task automatic test_ram_access();
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_I, 4'h3));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_E, 4'hF));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_F, 4'hF));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_D, 4'hF));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_C, 4'hF));
    send_item(make_item(plsk_pkg::MODE_READ_C, plsk_pkg::PORT_C, 4'h0));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_I, 4'h2));
    send_item(make_item(plsk_pkg::MODE_READ_C, plsk_pkg::PORT_C, 4'h0));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_I, 4'h0));
    send_item(make_item(plsk_pkg::MODE_READ_C, plsk_pkg::PORT_C, 4'h0));
    send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_G, 4'hF));
  endtask

  // one well-formed access sequence with random content, or noise
  task automatic random_sequence();
    int         pick;
    logic [3:0] strobe;
    pick      = $urandom_range(99, 0);
    strobe    = rand_nib();
    strobe[1] = ce_level;
    strobe[0] = we_level;
    if (pick < 40) begin
      send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_I, strobe));
      repeat ($urandom_range(2, 0))
        send_item(make_item(plsk_pkg::MODE_WRITE, addr_port(), pool_nib()));
      repeat ($urandom_range(3, 1))
        send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_C, rand_nib()));
    end else if (pick < 65) begin
      strobe[0] = ~we_level;
      send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_I, strobe));
      repeat ($urandom_range(2, 0))
        send_item(make_item(plsk_pkg::MODE_WRITE, addr_port(), pool_nib()));
      repeat ($urandom_range(3, 1))
        send_item(make_item(plsk_pkg::MODE_READ_C, rand_nib(), rand_nib()));
    end else if (pick < 85) begin
      send_item(make_item(plsk_pkg::MODE_WRITE, plsk_pkg::PORT_H,
                          ($urandom_range(3, 0) == 0) ? 4'hF : rand_nib()));
      repeat ($urandom_range(4, 1))
        send_item(make_item(($urandom_range(1, 0) == 0) ? plsk_pkg::MODE_READ_A
                                                        : plsk_pkg::MODE_READ_B,
                            rand_nib(), rand_nib()));
    end else begin
      repeat ($urandom_range(3, 1))
        send_item(make_item(3'($urandom_range(7, 0)), rand_nib(), rand_nib()));
    end
  endtask

  // random traffic under every pair of active levels, then random pairs
  task automatic test_random_traffic();
    int start;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase < 4) set_levels(phase[1], phase[0]);
      else set_levels(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      start = accepted_items;
      while (accepted_items - start < PHASE_ITEMS) random_sequence();
    end
  endtask

  // main sequence
  initial begin
    data_nib   = '0;
    rhythm_nib = '0;
    bank_nib   = '0;
    step_nib   = '0;
    scan_nib   = '0;
    strobe_nib = '0;
    dirty_seen = 1'b0;
    ce_level   = 1'b1;
    we_level   = 1'b1;
    for (int i = 0; i < plsk_pkg::RAM_DEPTH; i++) ram_image[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_spare_codes();
    test_key_scan();
    test_ram_access();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= 2'($urandom_range(2, 0));
      stall_span  <= $urandom_range(60, 4);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
      default:     out_stall <= ($urandom_range(7, 0) < 5);
    endcase
  end

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: expected no result, got %p", $time, out_item);
        mismatch_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("read_data", oldest_result.read_data, out_item.read_data);
        check_field("write_forward", 4'(oldest_result.write_forward),
                    4'(out_item.write_forward));
        check_field("forward_port", oldest_result.forward_port, out_item.forward_port);
        check_field("forward_data", oldest_result.forward_data, out_item.forward_data);
        check_field("ram_dirty", 4'(oldest_result.ram_dirty), 4'(out_item.ram_dirty));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WATCHDOG_CYCLES) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+src
src/plsk_pkg.sv
src/plsk_ram.sv
src/port_latch_sram_keyscan_glue.sv
tb/sv/testbench.sv
